// File: hdl/chme_pkg.sv
// Shared types and constants of the chained hash map engine.
package chme_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int OP_W  = 2;
    localparam int ST_W  = 3;
    localparam int CNT_W = 9;
    localparam int CFG_W = 7;
    localparam int REM_W = CFG_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FOUND    = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic div;
        logic head_take;
        logic node_cmp;
        logic act;
        logic alloc;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic div_last;
        logic op_nop;
        logic walk_end;
        logic key_match;
        logic alloc_go;
    } t_sts;

endpackage

// File: hdl/chained_hash_map_engine_top.sv
// Top level of the chained hash map engine.
//
//  channel   | signals                                   | transaction
//  ----------+-------------------------------------------+-------------------------------
//  request   | start, busy, i_op, i_key, i_value         | start high while busy is low
//  result    | o_done, o_status, o_read_value,           | o_done high for one cycle
//            | o_entry_count                             |
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_data      | valid and ready both high
//
// A request is accepted in the idle state, then passes the bucket modulo unit, the
// bucket head read, the chain walk, the update step, a node allocation on a new insert
// and the result state. An unused op code skips the walk and goes from the modulo unit
// straight to the result. The modulo unit retires two quotient bits a cycle;
// each chain step is one registered read of the node memories and one compare.
// After reset a clearing pass empties the bucket heads and fills the free stack; busy
// stays high meanwhile. Config is always ready.
// Results cannot be stalled: each is shown once, the cycle o_done is high.
module chained_hash_map_engine_top #(
    parameter int BUCKETS = 64,
    parameter int NODES   = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [chme_pkg::OP_W-1:0]         i_op,
    input  logic signed [chme_pkg::KEY_W-1:0] i_key,
    input  logic signed [chme_pkg::VAL_W-1:0] i_value,
    output logic                              o_done,
    output logic [chme_pkg::ST_W-1:0]         o_status,
    output logic signed [chme_pkg::VAL_W-1:0] o_read_value,
    output logic [chme_pkg::CNT_W-1:0]        o_entry_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [chme_pkg::CFG_W-1:0]        i_cfg_data
);
    import chme_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // bucket count register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: clear pass, modulo, chain walk, update, result strobe
    chme_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // datapath: request registers, modulo unit, node and free stack memories
    chme_dp #(
        .BUCKETS (BUCKETS),
        .NODES   (NODES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count)
    );
endmodule

// File: hdl/chme_ram.sv
// Generic simple dual-port RAM with registered read.
module chme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/chme_ctrl.sv
// Request sequencer of the hash map engine.
module chme_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  chme_pkg::t_sts i_sts,
    output chme_pkg::t_cmd o_cmd,
    output logic           o_busy,
    output logic           o_done
);
    import chme_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR     = 10'b0000000001,
        S_IDLE      = 10'b0000000010,
        S_DIV       = 10'b0000000100,
        S_HEAD_RD   = 10'b0000001000,
        S_HEAD_TAKE = 10'b0000010000,
        S_WALK      = 10'b0000100000,
        S_CMP       = 10'b0001000000,
        S_ACT       = 10'b0010000000,
        S_ALLOC     = 10'b0100000000,
        S_DONE      = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) n_state = i_sts.op_nop ? S_DONE : S_HEAD_RD;
            end
            S_HEAD_RD: n_state = S_HEAD_TAKE;
            S_HEAD_TAKE: begin
                o_cmd.head_take = 1'b1;
                n_state         = S_WALK;
            end
            S_WALK: n_state = i_sts.walk_end ? S_ACT : S_CMP;
            S_CMP: begin
                o_cmd.node_cmp = 1'b1;
                n_state        = i_sts.key_match ? S_ACT : S_WALK;
            end
            S_ACT: begin
                o_cmd.act = 1'b1;
                n_state   = i_sts.alloc_go ? S_ALLOC : S_DONE;
            end
            S_ALLOC: begin
                o_cmd.alloc = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

`ifndef ASSERT_OFF
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held longer than one cycle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("accepted request not started");
    a_alloc_after_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.alloc |-> $past(o_cmd.act)) else $error("alloc without act");
`endif
endmodule

// File: hdl/chme_dp.sv
// Datapath of the hash map engine: modulo unit, node memories, free stack.
module chme_dp #(
    parameter int BUCKETS = 64,
    parameter int NODES   = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [chme_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [chme_pkg::OP_W-1:0]           i_op,
    input  logic signed [chme_pkg::KEY_W-1:0]   i_key,
    input  logic signed [chme_pkg::VAL_W-1:0]   i_value,
    input  chme_pkg::t_cmd                      i_cmd,
    output chme_pkg::t_sts                      o_sts,
    output logic [chme_pkg::ST_W-1:0]           o_status,
    output logic signed [chme_pkg::VAL_W-1:0]   o_read_value,
    output logic [chme_pkg::CNT_W-1:0]          o_entry_count
);
    import chme_pkg::*;

    localparam int NIW       = $clog2(NODES);
    localparam int LW        = NIW + 1;
    localparam int BIW       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CLR_N     = (BUCKETS > NODES) ? BUCKETS : NODES;
    localparam int CLW       = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam int DIV_STEPS = KEY_W / 2;
    localparam int DCW       = $clog2(DIV_STEPS);
    localparam int CFG_MAX   = (1 << CFG_W) - 1;
    localparam int CFG_RST   = (BUCKETS > CFG_MAX) ? CFG_MAX : BUCKETS;
    localparam logic [LW-1:0] END_MARK = LW'(NODES);

    // control state
    logic [CFG_W-1:0] r_bucket_count;
    logic [LW-1:0]    r_free_top;
    logic [LW-1:0]    r_count;
    logic [CLW-1:0]   r_clr;
    logic [DCW-1:0]   r_div_cnt;

    // per-request payload
    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic [KEY_W-1:0] r_mag;
    logic [REM_W-1:0] r_rem;
    logic [CFG_W-1:0] r_mod;
    logic [LW-1:0]    r_head;
    logic [LW-1:0]    r_cur;
    logic [LW-1:0]    r_prev;
    logic [LW-1:0]    r_steps;
    logic             r_hit;
    logic [VAL_W-1:0] r_nval;
    logic [LW-1:0]    r_nlink;
    logic [ST_W-1:0]  r_status;
    logic [VAL_W-1:0] r_rd;

    // memory read data
    logic [LW-1:0]    head_q;
    logic [KEY_W-1:0] key_q;
    logic [VAL_W-1:0] val_q;
    logic [LW-1:0]    link_q;
    logic [NIW-1:0]   fs_q;

    logic [KEY_W-1:0] key_u;
    logic [KEY_W-1:0] mag_in;
    logic [CFG_W-1:0] mod_in;
    logic [REM_W-1:0] t1, d1, t2, d2;
    logic [31:0]      rem_ext;
    logic [31:0]      clr_ext;
    logic [31:0]      cnt_ext;
    logic [BIW-1:0]   bucket;
    logic [BIW-1:0]   clr_b;
    logic [NIW-1:0]   clr_n;
    logic [NIW-1:0]   cur_idx;
    logic [NIW-1:0]   prev_idx;
    logic [NIW-1:0]   top_idx;
    logic [LW-1:0]    top_m1;
    logic             clr_in_b;
    logic             clr_in_n;
    logic             is_ins, is_rem;
    logic             top_room;

    logic             head_we;
    logic [BIW-1:0]   head_waddr;
    logic [LW-1:0]    head_wdata;
    logic             val_we;
    logic [NIW-1:0]   val_waddr;
    logic             link_we;
    logic [NIW-1:0]   link_waddr;
    logic [LW-1:0]    link_wdata;
    logic             fs_we;
    logic [NIW-1:0]   fs_waddr;
    logic [NIW-1:0]   fs_wdata;

    always_comb begin
        key_u  = unsigned'(i_key);
        mag_in = key_u[KEY_W-1] ? (~key_u + KEY_W'(1)) : key_u;
        if (i_cfg_data == '0 && r_bucket_count == '0) begin
            mod_in = CFG_W'(1);
        end else if (r_bucket_count == '0) begin
            mod_in = CFG_W'(1);
        end else if (32'(r_bucket_count) > 32'(BUCKETS)) begin
            mod_in = CFG_W'(CFG_RST);
        end else begin
            mod_in = r_bucket_count;
        end
        // two restoring steps per cycle
        t1 = {r_rem[REM_W-2:0], r_mag[KEY_W-1]};
        d1 = (t1 >= {1'b0, r_mod}) ? (t1 - {1'b0, r_mod}) : t1;
        t2 = {d1[REM_W-2:0], r_mag[KEY_W-2]};
        d2 = (t2 >= {1'b0, r_mod}) ? (t2 - {1'b0, r_mod}) : t2;
    end

    assign rem_ext  = 32'(r_rem);
    assign bucket   = rem_ext[BIW-1:0];
    assign clr_ext  = 32'(r_clr);
    assign clr_b    = clr_ext[BIW-1:0];
    assign clr_n    = clr_ext[NIW-1:0];
    assign clr_in_b = (clr_ext < 32'(BUCKETS));
    assign clr_in_n = (clr_ext < 32'(NODES));
    assign cur_idx  = r_cur[NIW-1:0];
    assign prev_idx = r_prev[NIW-1:0];
    assign top_idx  = r_free_top[NIW-1:0];
    assign top_m1   = r_free_top - LW'(1);
    assign is_ins   = (r_op == OP_INSERT);
    assign is_rem   = (r_op == OP_REMOVE);
    assign top_room = (r_free_top < END_MARK);

    assign o_sts.clear_last = (r_clr == CLW'(CLR_N - 1));
    assign o_sts.div_last   = (r_div_cnt == DCW'(DIV_STEPS - 1));
    assign o_sts.op_nop     = (r_op == OP_NOP);
    assign o_sts.walk_end   = (r_cur >= END_MARK) || (r_steps == END_MARK);
    assign o_sts.key_match  = (key_q == r_key);
    assign o_sts.alloc_go   = is_ins && !r_hit && (r_free_top != '0)
                              && (r_free_top <= END_MARK);

    // memory write steering
    always_comb begin
        head_we    = (i_cmd.clear && clr_in_b) || i_cmd.alloc
                     || (i_cmd.act && is_rem && r_hit && r_prev == END_MARK);
        head_waddr = i_cmd.clear ? clr_b : bucket;
        head_wdata = i_cmd.clear ? END_MARK : (i_cmd.alloc ? {1'b0, fs_q} : r_nlink);

        val_we     = i_cmd.alloc || (i_cmd.act && is_ins && r_hit);
        val_waddr  = i_cmd.alloc ? fs_q : cur_idx;

        link_we    = i_cmd.alloc || (i_cmd.act && is_rem && r_hit && r_prev != END_MARK);
        link_waddr = i_cmd.alloc ? fs_q : prev_idx;
        link_wdata = i_cmd.alloc ? r_head : r_nlink;

        fs_we      = (i_cmd.clear && clr_in_n) || (i_cmd.act && is_rem && r_hit && top_room);
        fs_waddr   = i_cmd.clear ? clr_n : top_idx;
        fs_wdata   = i_cmd.clear ? clr_n : cur_idx;
    end

    chme_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(bucket), .o_rdata(head_q)
    );
    chme_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_key (
        .i_clk(i_clk), .i_we(i_cmd.alloc), .i_waddr(fs_q), .i_wdata(r_key),
        .i_raddr(cur_idx), .o_rdata(key_q)
    );
    chme_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_val (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_waddr), .i_wdata(r_val),
        .i_raddr(cur_idx), .o_rdata(val_q)
    );
    chme_ram #(.WIDTH(LW), .DEPTH(NODES)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr), .i_wdata(link_wdata),
        .i_raddr(cur_idx), .o_rdata(link_q)
    );
    chme_ram #(.WIDTH(NIW), .DEPTH(NODES)) u_free (
        .i_clk(i_clk), .i_we(fs_we), .i_waddr(fs_waddr), .i_wdata(fs_wdata),
        .i_raddr(top_m1[NIW-1:0]), .o_rdata(fs_q)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= CFG_W'(CFG_RST);
            r_free_top     <= END_MARK;
            r_count        <= '0;
            r_clr          <= '0;
            r_div_cnt      <= '0;
        end else begin
            if (i_cfg_we) r_bucket_count <= i_cfg_data;
            if (i_cmd.clear) r_clr <= r_clr + CLW'(1);
            if (i_cmd.load) r_div_cnt <= '0;
            else if (i_cmd.div) r_div_cnt <= r_div_cnt + DCW'(1);
            if (i_cmd.act) begin
                if (o_sts.alloc_go) begin
                    r_free_top <= top_m1;
                    r_count    <= r_count + LW'(1);
                end else if (is_rem && r_hit) begin
                    if (top_room) r_free_top <= r_free_top + LW'(1);
                    if (r_count != '0) r_count <= r_count - LW'(1);
                end
            end
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_key    <= key_u;
            r_val    <= unsigned'(i_value);
            r_mag    <= mag_in;
            r_rem    <= '0;
            r_mod    <= mod_in;
            r_hit    <= 1'b0;
            r_status <= ST_ABSENT;
            r_rd     <= '0;
        end
        if (i_cmd.div) begin
            r_rem <= d2;
            r_mag <= {r_mag[KEY_W-3:0], 2'b00};
        end
        if (i_cmd.head_take) begin
            r_head  <= head_q;
            r_cur   <= head_q;
            r_prev  <= END_MARK;
            r_steps <= '0;
        end
        if (i_cmd.node_cmp) begin
            if (o_sts.key_match) begin
                r_hit   <= 1'b1;
                r_nval  <= val_q;
                r_nlink <= link_q;
            end else begin
                r_prev  <= r_cur;
                r_cur   <= link_q;
                r_steps <= r_steps + LW'(1);
            end
        end
        if (i_cmd.act) begin
            case (r_op)
                OP_INSERT: begin
                    if (r_hit) r_status <= ST_UPDATED;
                    else if (o_sts.alloc_go) r_status <= ST_INSERTED;
                    else r_status <= ST_FULL;
                end
                OP_LOOKUP: begin
                    if (r_hit) begin
                        r_status <= ST_FOUND;
                        r_rd     <= r_nval;
                    end
                end
                OP_REMOVE: begin
                    if (r_hit) r_status <= ST_FOUND;
                end
                default: r_status <= ST_ABSENT;
            endcase
        end
    end

    assign cnt_ext       = 32'(r_count);
    assign o_status      = r_status;
    assign o_read_value  = signed'(r_rd);
    assign o_entry_count = cnt_ext[CNT_W-1:0];

`ifndef ASSERT_OFF
    a_pool_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_free_top) + 32'(r_count)) == 32'(NODES))
        else $error("free stack and entry count out of balance");
    a_alloc_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |-> (r_free_top == $past(r_free_top) - LW'(1)))
        else $error("node allocated without free stack pop");
`endif
endmodule

// File: sim/chained_hash_map_engine_top_test.sv
// Self-checking testbench for the chained hash map engine top level.
module chained_hash_map_engine_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import chme_pkg::*;

    localparam int BUCKETS  = 64;
    localparam int NODES    = 256;
    localparam int KEY_POOL = 320;
    // Longest request: modulo, a full chain walk of NODES steps, plus overhead,
    // plus the longest sender gap and the clearing pass, taken several times over.
    localparam int STALL_LIMIT = 8 * (24 + 2 * NODES + 17 + NODES);

    // Expected outcome of one request.
    typedef struct {
        t_status     status;
        logic [31:0] read_value;
        logic [8:0]  entry_count;
    } t_outcome;

    // Shadow copy of the hash map; predicts each outcome and checks results in order.
    class HashMapScoreboard;
        int          buckets_cfg;
        int          bucket_head [BUCKETS];
        logic [31:0] node_key    [NODES];
        logic [31:0] node_value  [NODES];
        int          node_link   [NODES];
        int          free_stack  [NODES];
        int          free_top;
        int          stored;
        t_outcome    pending_q[$];
        int          errors;

        function new();
            buckets_cfg = BUCKETS;
            for (int i = 0; i < BUCKETS; i++) bucket_head[i] = NODES;
            for (int i = 0; i < NODES; i++) begin
                node_key[i]   = '0;
                node_value[i] = '0;
                node_link[i]  = NODES;
                free_stack[i] = i;
            end
            free_top = NODES;
            stored   = 0;
            errors   = 0;
        endfunction

        function void set_buckets(logic [CFG_W-1:0] data);
            buckets_cfg = data;
        endfunction

        // |key| modulo the active bucket count; zero acts as one, large saturates
        function int bucket_of(logic [31:0] key);
            logic [32:0] mag;
            int          m;
            m   = (buckets_cfg == 0) ? 1 : (buckets_cfg > BUCKETS ? BUCKETS : buckets_cfg);
            mag = key[31] ? ({1'b0, ~key} + 33'd1) : {1'b0, key};
            return int'(mag % m);
        endfunction

        function void note_request(t_op op, logic [31:0] key, logic [31:0] val);
            t_outcome o;
            int       b, cur, prev, steps;
            bit       hit;
            o.status     = ST_ABSENT;
            o.read_value = '0;
            b     = bucket_of(key);
            cur   = bucket_head[b];
            prev  = NODES;
            steps = 0;
            hit   = 0;
            if (op != OP_NOP) begin
                while (cur < NODES && steps < NODES) begin
                    if (node_key[cur] == key) begin
                        hit = 1;
                        break;
                    end
                    prev = cur;
                    cur  = node_link[cur];
                    steps++;
                end
            end
            case (op)
                OP_INSERT: begin
                    if (hit) begin
                        node_value[cur] = val;
                        o.status = ST_UPDATED;
                    end else if (free_top == 0) begin
                        o.status = ST_FULL;
                    end else begin
                        int n;
                        free_top--;
                        n = free_stack[free_top];
                        node_key[n]    = key;
                        node_value[n]  = val;
                        node_link[n]   = bucket_head[b];
                        bucket_head[b] = n;
                        stored++;
                        o.status = ST_INSERTED;
                    end
                end
                OP_LOOKUP: begin
                    if (hit) begin
                        o.read_value = node_value[cur];
                        o.status     = ST_FOUND;
                    end
                end
                OP_REMOVE: begin
                    if (hit) begin
                        if (prev == NODES) bucket_head[b] = node_link[cur];
                        else node_link[prev] = node_link[cur];
                        if (free_top < NODES) begin
                            free_stack[free_top] = cur;
                            free_top++;
                        end
                        if (stored > 0) stored--;
                        o.status = ST_FOUND;
                    end
                end
                default: ;
            endcase
            o.entry_count = stored[8:0];
            pending_q.push_back(o);
        endfunction

        function void check_result(logic [ST_W-1:0] status, logic [31:0] rd,
                                   logic [CNT_W-1:0] cnt);
            t_outcome o;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d read_value=%h entry_count=%0d",
                         $time, status, rd, cnt);
                errors++;
                return;
            end
            o = pending_q.pop_front();
            if (status !== o.status) begin
                $display("%0t: status expected %0d actual %0d", $time, o.status, status);
                errors++;
            end
            if (rd !== o.read_value) begin
                $display("%0t: read_value expected %h actual %h", $time, o.read_value, rd);
                errors++;
            end
            if (cnt !== o.entry_count) begin
                $display("%0t: entry_count expected %0d actual %0d",
                         $time, o.entry_count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [OP_W-1:0]          i_op;
    logic signed [KEY_W-1:0]  i_key;
    logic signed [VAL_W-1:0]  i_value;
    logic                     o_done;
    logic [ST_W-1:0]          o_status;
    logic signed [VAL_W-1:0]  o_read_value;
    logic [CNT_W-1:0]         o_entry_count;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_W-1:0]         i_cfg_data;

    HashMapScoreboard sb;
    logic [31:0]      key_pool[KEY_POOL];
    int               idle_cycles;   // cycles since the last accepted transaction
    bit               gaps_on;

    chained_hash_map_engine_top #(.BUCKETS(BUCKETS), .NODES(NODES)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Results cannot be held off: every o_done cycle is one transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_status, o_read_value, o_entry_count);
    end

    // Watchdog: any accepted request, result or config write resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // One request transaction; start is lowered at the accepting edge and only
    // raised again at a later edge.
    task automatic send_request(t_op op, logic [31:0] key, logic [31:0] val);
        if (gaps_on && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 17)) @(posedge i_clk);
        @(posedge i_clk);
        start   <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        i_value <= val;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        start <= 1'b0;
        sb.note_request(op, key, val);
    endtask

    // Let every outstanding result come back and the engine go quiet.
    task automatic drain();
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Only called with the engine idle.
    task automatic write_buckets(logic [CFG_W-1:0] data);
        drain();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        i_cfg_valid <= 1'b0;
        sb.set_buckets(data);
    endtask

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return key_pool[$urandom_range(0, KEY_POOL - 1)];
        if (r < 83) return 32'h8000_0000;
        if (r < 86) return 32'h7FFF_FFFF;
        return $urandom;
    endfunction

    // Mixed traffic; ins_pct of the requests are inserts, a few are no-ops.
    task automatic random_traffic(int count, int ins_pct);
        int r;
        t_op op;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct) op = OP_INSERT;
            else if (r < ins_pct + (100 - ins_pct) / 2) op = OP_LOOKUP;
            else if (r < 97) op = OP_REMOVE;
            else op = OP_NOP;
            send_request(op, pick_key(), $urandom);
        end
    endtask

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_op        <= OP_NOP;
        i_key       <= '0;
        i_value     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        gaps_on      = 1'b1;
        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h0000_0040;   // same bucket as zero with 64 buckets
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, chains in one bucket, update, head and middle removal.
        send_request(OP_INSERT, 32'h0000_0000, 32'h7FFF_FFFF);
        send_request(OP_INSERT, 32'h8000_0000, 32'h8000_0000);  // |min| = 2^31, bucket 0
        send_request(OP_INSERT, 32'h0000_0040, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h1234_5678);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0001);
        send_request(OP_LOOKUP, 32'h8000_0000, 32'h0);
        send_request(OP_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h8000_0000, 32'h5555_AAAA);  // update
        send_request(OP_LOOKUP, 32'h8000_0000, 32'h0);
        send_request(OP_REMOVE, 32'h8000_0000, 32'h0);          // middle of chain
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0);
        send_request(OP_REMOVE, 32'h0000_0040, 32'h0);          // head of chain
        send_request(OP_LOOKUP, 32'h0000_0040, 32'h0);
        send_request(OP_REMOVE, 32'h0000_0040, 32'h0);          // already gone
        send_request(OP_LOOKUP, 32'h0000_0080, 32'h0);          // never stored
        send_request(OP_NOP,    32'h0000_0000, 32'hFFFF_FFFF);  // unused code
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0);
        send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);

        // Single bucket: fill past the pool size to hit pool full, with lookups mixed in.
        write_buckets(7'd1);
        for (int i = 0; i < 300; i++) begin
            send_request(OP_INSERT, key_pool[i], $urandom);
            if ($urandom_range(0, 4) == 0) send_request(OP_LOOKUP, pick_key(), $urandom);
        end
        random_traffic(40, 30);

        // Zero acts as one bucket; keys stay reachable.
        write_buckets(7'd0);
        random_traffic(150, 30);

        // Above the table size saturates; old keys mostly absent now.
        write_buckets(7'h7F);
        random_traffic(200, 40);

        write_buckets(7'd7);
        random_traffic(120, 40);

        // Last stretch without any sender gaps.
        write_buckets(7'd64);
        gaps_on = 1'b0;
        random_traffic(120, 40);

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// File: filelist.f
hdl/chme_pkg.sv
hdl/chme_ram.sv
hdl/chme_ctrl.sv
hdl/chme_dp.sv
hdl/chained_hash_map_engine_top.sv
sim/chained_hash_map_engine_top_test.sv
